/* src/smsort_pkg.sv */
// Shared types, constants and the key compare for the stable merge sorter.
// No dependencies; used by the sorter top level and its port checker.
package smsort_pkg;

    // Field widths of one item on the ports
    localparam int KEY_MAX_W     = 32;
    localparam int PAYLOAD_MAX_W = 32;

    // Defaults for the top-level parameters
    localparam int MAX_RECORDS_DEF   = 64;
    localparam int KEY_WIDTH_DEF     = 32;
    localparam int PAYLOAD_WIDTH_DEF = 32;

    // order_mode register
    localparam int MODE_W          = 2;
    localparam int MODE_DESC_BIT   = 0;
    localparam int MODE_SIGNED_BIT = 1;

    typedef struct packed {
        logic [KEY_MAX_W-1:0]     record_key;
        logic [PAYLOAD_MAX_W-1:0] record_payload;
        logic                     batch_end;
    } in_item_t;

    typedef struct packed {
        logic [KEY_MAX_W-1:0]     sorted_key;
        logic [PAYLOAD_MAX_W-1:0] sorted_payload;
        logic                     final_record;
    } out_item_t;

    // True when the left rank goes first; ties go left (stable)
    function automatic logic smsort_before(
        input logic [KEY_MAX_W-1:0] rank_a,
        input logic [KEY_MAX_W-1:0] rank_b,
        input logic                 desc
    );
        logic res;
        if (desc)
        begin
            res = (rank_a >= rank_b);
        end
        else
        begin
            res = (rank_a <= rank_b);
        end
        return res;
    endfunction

endpackage

/* src/smsort_mem.sv */
// Simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; instantiated twice by the sorter top level.
module smsort_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/stable_merge_sorter_top.sv */
// Stable merge sorter: loads a batch, bottom-up merge sorts it between two RAMs, emits it.
// Load takes items while in_valid is high; the sort makes ceil(log2 n) passes over runs of doubling width.
// Emit: per sorted item, one RAM read (one in flight at a time), then the output load.
// Next batch loads while the last sorted item waits in the output register.
// Reset (rst_n, async, low): FSM, count, order_mode and output valid clear; RAMs keep contents.
// Depends on smsort_pkg and smsort_mem.
module stable_merge_sorter_top
    import smsort_pkg::*;
#(
    parameter int MAX_RECORDS   = MAX_RECORDS_DEF,
    parameter int KEY_WIDTH     = KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // input items
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_item,
    // sorted items
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_item,
    // order_mode register
    input  logic              cfg_we,
    input  logic [MODE_W-1:0] cfg_wdata
);

    // RAM address, count (holds MAX_RECORDS) and merge index widths.
    // Merge indices get one extra bit: lo + 2*width stays below 2*n.
    localparam int AW     = $clog2(MAX_RECORDS);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int SW     = CNT_W + 1;
    localparam int EW     = KEY_WIDTH + PAYLOAD_WIDTH;
    localparam logic [KEY_WIDTH-1:0] SIGN_MASK = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

    typedef enum logic [2:0] {
        S_LOAD,       // take items into bank A
        S_FETCH,      // start of a run: read left head
        S_RD_L,       // capture left head
        S_RD_R,       // capture right head
        S_MERGE,      // write one record to the destination bank
        S_EMIT_RD,    // read next sorted record
        S_EMIT_WAIT   // move it into the output register
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [SW-1:0]       width_reg, width_next;
    logic [SW-1:0]       lo_reg, lo_next;
    logic [SW-1:0]       mid_reg, mid_next;
    logic [SW-1:0]       hi_reg, hi_next;
    logic [SW-1:0]       i_reg, i_next;
    logic [SW-1:0]       j_reg, j_next;
    logic [SW-1:0]       k_reg, k_next;
    logic                init_reg, init_next;
    logic                src_sel_reg, src_sel_next;   // 0: bank A is the merge source
    logic [EW-1:0]       head_l_reg, head_l_next;
    logic [EW-1:0]       head_r_reg, head_r_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_item_reg, out_item_next;

    // shared RAM access, steered to a bank below
    logic                wr_en, wr_sel_b, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [EW-1:0]       wr_data, rd_data, rdata_a, rdata_b;

    // next-run bookkeeping
    logic [SW-1:0]       n_ext, step2, nxt_lo, run_lo, run_w, run_end_a, run_end_b;
    logic [SW-1:0]       run_mid, run_hi;
    logic                pass_done, sort_done;

    // compare of the two heads
    logic [KEY_WIDTH-1:0] rank_l, rank_r;
    logic                 left_ok, right_ok, take_l;

    smsort_mem #(.DEPTH(MAX_RECORDS), .WIDTH(EW), .AW(AW)) u_bank_a (
        .clk   (clk),
        .we    (wr_en && !wr_sel_b),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en && !src_sel_reg),
        .raddr (rd_addr),
        .rdata (rdata_a)
    );

    smsort_mem #(.DEPTH(MAX_RECORDS), .WIDTH(EW), .AW(AW)) u_bank_b (
        .clk   (clk),
        .we    (wr_en && wr_sel_b),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en && src_sel_reg),
        .raddr (rd_addr),
        .rdata (rdata_b)
    );

    // Source bank only changes when no read is outstanding
    assign rd_data = src_sel_reg ? rdata_b : rdata_a;

    // Where the merge goes after the current run ends
    always_comb
    begin
        n_ext     = SW'(n_reg);
        step2     = width_reg << 1;
        nxt_lo    = lo_reg + step2;
        pass_done = (nxt_lo >= n_ext);
        sort_done = pass_done && (step2 >= n_ext);
        run_lo    = pass_done ? '0 : nxt_lo;
        run_w     = pass_done ? step2 : width_reg;
        run_end_a = run_lo + run_w;
        run_end_b = run_lo + (run_w << 1);
        run_mid   = (run_end_a > n_ext) ? n_ext : run_end_a;
        run_hi    = (run_end_b > n_ext) ? n_ext : run_end_b;
    end

    // Key order: flipping the sign bit makes signed keys compare as unsigned
    always_comb
    begin
        rank_l   = head_l_reg[EW-1:PAYLOAD_WIDTH];
        rank_r   = head_r_reg[EW-1:PAYLOAD_WIDTH];
        if (mode_reg[MODE_SIGNED_BIT])
        begin
            rank_l = rank_l ^ SIGN_MASK;
            rank_r = rank_r ^ SIGN_MASK;
        end
        left_ok  = (i_reg < mid_reg);
        right_ok = (j_reg < hi_reg);
        take_l   = left_ok && (!right_ok ||
                   smsort_before(KEY_MAX_W'(rank_l), KEY_MAX_W'(rank_r),
                                 mode_reg[MODE_DESC_BIT]));
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        width_next     = width_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        init_next      = init_reg;
        src_sel_next   = src_sel_reg;
        head_l_next    = head_l_reg;
        head_r_next    = head_r_reg;
        mode_next      = cfg_we ? cfg_wdata : mode_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;

        wr_en    = 1'b0;
        wr_sel_b = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        rd_en    = 1'b0;
        rd_addr  = '0;

        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = count_reg[AW-1:0];
                    wr_data  = {in_item.record_key[KEY_WIDTH-1:0],
                                in_item.record_payload[PAYLOAD_WIDTH-1:0]};
                    count_next = count_reg + CNT_W'(1);
                    if (in_item.batch_end || (count_reg + CNT_W'(1) == CNT_W'(MAX_RECORDS)))
                    begin
                        n_next       = count_reg + CNT_W'(1);
                        count_next   = '0;
                        src_sel_next = 1'b0;
                        k_next       = '0;
                        if (count_reg == '0)
                        begin
                            // single record: straight out
                            state_next = S_EMIT_RD;
                        end
                        else
                        begin
                            width_next = SW'(1);
                            lo_next    = '0;
                            mid_next   = SW'(1);
                            hi_next    = SW'(2);
                            i_next     = '0;
                            j_next     = SW'(1);
                            state_next = S_FETCH;
                        end
                    end
                end
            end

            S_FETCH:
            begin
                rd_en      = 1'b1;
                rd_addr    = i_reg[AW-1:0];
                init_next  = 1'b1;
                state_next = S_RD_L;
            end

            S_RD_L:
            begin
                head_l_next = rd_data;
                init_next   = 1'b0;
                if (init_reg && (j_reg < hi_reg))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = j_reg[AW-1:0];
                    state_next = S_RD_R;
                end
                else
                begin
                    state_next = S_MERGE;
                end
            end

            S_RD_R:
            begin
                head_r_next = rd_data;
                state_next  = S_MERGE;
            end

            S_MERGE:
            begin
                wr_en    = 1'b1;
                wr_sel_b = !src_sel_reg;
                wr_addr  = k_reg[AW-1:0];
                wr_data  = take_l ? head_l_reg : head_r_reg;
                k_next   = k_reg + SW'(1);
                if (k_reg + SW'(1) == hi_reg)
                begin
                    if (sort_done)
                    begin
                        src_sel_next = !src_sel_reg;
                        k_next       = '0;
                        state_next   = S_EMIT_RD;
                    end
                    else
                    begin
                        if (pass_done)
                        begin
                            src_sel_next = !src_sel_reg;
                        end
                        width_next = run_w;
                        lo_next    = run_lo;
                        mid_next   = run_mid;
                        hi_next    = run_hi;
                        i_next     = run_lo;
                        j_next     = run_mid;
                        k_next     = run_lo;
                        state_next = S_FETCH;
                    end
                end
                else if (take_l)
                begin
                    i_next = i_reg + SW'(1);
                    if (i_reg + SW'(1) < mid_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = i_next[AW-1:0];
                        state_next = S_RD_L;
                    end
                end
                else
                begin
                    j_next = j_reg + SW'(1);
                    if (j_reg + SW'(1) < hi_reg)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = j_next[AW-1:0];
                        state_next = S_RD_R;
                    end
                end
            end

            S_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = k_reg[AW-1:0];
                state_next = S_EMIT_WAIT;
            end

            S_EMIT_WAIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next               = 1'b1;
                    out_item_next.sorted_key     = KEY_MAX_W'(rd_data[EW-1:PAYLOAD_WIDTH]);
                    out_item_next.sorted_payload = PAYLOAD_MAX_W'(rd_data[PAYLOAD_WIDTH-1:0]);
                    out_item_next.final_record   = (k_reg + SW'(1) == n_ext);
                    if (k_reg + SW'(1) == n_ext)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + SW'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            n_reg         <= '0;
            width_reg     <= '0;
            lo_reg        <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            init_reg      <= 1'b0;
            src_sel_reg   <= 1'b0;
            head_l_reg    <= '0;
            head_r_reg    <= '0;
            mode_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            width_reg     <= width_next;
            lo_reg        <= lo_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            init_reg      <= init_next;
            src_sel_reg   <= src_sel_next;
            head_l_reg    <= head_l_next;
            head_r_reg    <= head_r_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    // Loading only; sort and emit hold the input off
    assign in_stall  = (state_reg != S_LOAD);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* src/smsort_checker.sv */
// Port-level checks for the stable merge sorter, bound to its top level.
// Depends on smsort_pkg and stable_merge_sorter_top.
module smsort_checker
    import smsort_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_item_t  in_item,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    // stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("sorted item changed while stalled");

    // the end of a batch starts the sort (or the emit, for a single record), so input stops next cycle
    a_end_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_item.batch_end |=> in_stall)
        else $error("input taken right after batch end");

    // while a batch is still draining, no new input is taken
    a_no_load_mid_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.final_record |-> in_stall)
        else $error("input open before last sorted item was produced");

endmodule

bind stable_merge_sorter_top smsort_checker u_smsort_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

/* test/smsort_order_checker.sv */
// Port checker for the stable merge sorter: predicts each sorted item and compares it.
// Depends on smsort_pkg; watches the input, output and order_mode ports of the block.
module smsort_order_checker
    import smsort_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  in_item_t          in_item,
    input  logic              out_valid,
    input  logic              out_stall,
    input  out_item_t         out_item,
    input  logic              cfg_we,
    input  logic [MODE_W-1:0] cfg_wdata,
    output int                fail_count,
    output int                pending_count
);

    typedef struct packed {
        logic [KEY_MAX_W-1:0]     key;
        logic [PAYLOAD_MAX_W-1:0] payload;
    } rec_t;

    logic [MODE_W-1:0] order_mode;
    rec_t              batch_recs[$];   // records loaded in the current batch
    rec_t              ordered_run[$];  // batch being put in sorted order
    out_item_t         sorted_due[$];   // sorted items not yet seen at the output

    always @(posedge clk or negedge rst_n)
    begin : predict_sorted
        rec_t                 rec;
        out_item_t            want;
        logic [KEY_MAX_W-1:0] sign_flip;
        logic [KEY_MAX_W-1:0] rank_new;
        logic [KEY_MAX_W-1:0] rank_old;
        int                   pos;
        bit                   stop;
        if (!rst_n)
        begin
            batch_recs.delete();
            sorted_due.delete();
            order_mode    = '0;
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                order_mode = cfg_wdata;
            end

            if (out_valid && !out_stall)
            begin
                if (sorted_due.size() == 0)
                begin
                    $error("sorted item with none expected: key %h payload %h",
                           out_item.sorted_key, out_item.sorted_payload);
                    fail_count++;
                end
                else
                begin
                    want = sorted_due.pop_front();
                    if (out_item.sorted_key !== want.sorted_key)
                    begin
                        $error("sorted_key: expected %h, got %h",
                               want.sorted_key, out_item.sorted_key);
                        fail_count++;
                    end
                    if (out_item.sorted_payload !== want.sorted_payload)
                    begin
                        $error("sorted_payload: expected %h, got %h",
                               want.sorted_payload, out_item.sorted_payload);
                        fail_count++;
                    end
                    if (out_item.final_record !== want.final_record)
                    begin
                        $error("final_record: expected %b, got %b",
                               want.final_record, out_item.final_record);
                        fail_count++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                rec.key     = in_item.record_key;
                rec.payload = in_item.record_payload;
                batch_recs.push_back(rec);
                if (in_item.batch_end || batch_recs.size() >= MAX_RECORDS)
                begin
                    // signed compare = unsigned compare with the sign bit flipped
                    sign_flip = order_mode[MODE_SIGNED_BIT] ?
                                {1'b1, {(KEY_MAX_W-1){1'b0}}} : '0;
                    // stable insertion: a later record only passes strictly worse ones
                    ordered_run.delete();
                    foreach (batch_recs[i])
                    begin
                        rec      = batch_recs[i];
                        rank_new = rec.key ^ sign_flip;
                        pos      = ordered_run.size();
                        stop     = 1'b0;
                        while (pos > 0 && !stop)
                        begin
                            rank_old = ordered_run[pos-1].key ^ sign_flip;
                            if (order_mode[MODE_DESC_BIT] ? (rank_new > rank_old)
                                                          : (rank_new < rank_old))
                            begin
                                pos--;
                            end
                            else
                            begin
                                stop = 1'b1;
                            end
                        end
                        ordered_run.insert(pos, rec);
                    end
                    foreach (ordered_run[i])
                    begin
                        want.sorted_key     = ordered_run[i].key;
                        want.sorted_payload = ordered_run[i].payload;
                        want.final_record   = (i == ordered_run.size() - 1);
                        sorted_due.push_back(want);
                    end
                    batch_recs.delete();
                end
            end
            pending_count = sorted_due.size();
        end
    end

endmodule

/* test/stable_merge_sorter_top_tb.sv */
// Testbench top for the stable merge sorter: clock, reset, stimulus and the verdict.
// Depends on smsort_pkg, stable_merge_sorter_top and smsort_order_checker.
module stable_merge_sorter_top_tb;
    import smsort_pkg::*;

    // order_mode settings by name
    localparam logic [MODE_W-1:0] ORDER_ASC_U  = 2'b00;
    localparam logic [MODE_W-1:0] ORDER_DESC_U = 2'b01;
    localparam logic [MODE_W-1:0] ORDER_ASC_S  = 2'b10;
    localparam logic [MODE_W-1:0] ORDER_DESC_S = 2'b11;

    localparam int RANDOM_ITEMS   = 200;
    localparam int MAX_GAP        = 16;
    // a full 64-record sort runs with no item moving on either channel
    localparam int WATCHDOG_LIMIT = 5000;
    // idle cycles after the last sorted item before a register write or the verdict
    localparam int SETTLE_CYCLES  = 50;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    in_item_t          in_item;
    logic              out_valid;
    logic              out_stall;
    out_item_t         out_item;
    logic              cfg_we;
    logic [MODE_W-1:0] cfg_wdata;

    int fail_count;
    int pending_count;

    // quiet flags switch off idling on one side for a whole phase
    bit tx_quiet;
    bit rx_quiet;

    stable_merge_sorter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    smsort_order_checker u_order_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_item       (in_item),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_item      (out_item),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: after each accepted item, stall for a random number of cycles.
    // The countdown runs whether or not an item is waiting, so stalls land on
    // sorting, emitting and idle phases alike.
    initial
    begin : receiver
        int  wait_left;
        bit  took;
        out_stall = 1'b0;
        wait_left = $urandom_range(0, MAX_GAP);
        forever
        begin
            @(posedge clk);
            took = out_valid && !out_stall;
            @(negedge clk);
            if (took)
            begin
                wait_left = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (wait_left > 0)
            begin
                out_stall <= 1'b1;
                wait_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        do
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        while (idle_cycles < WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Offer one item after a random gap and hold it until accepted.
    // Valid stays high after acceptance; the next call either keeps it up with
    // new data (no gap) or drops it at the next falling edge.
    task automatic send_record(input logic [KEY_MAX_W-1:0] key,
                               input logic [PAYLOAD_MAX_W-1:0] payload,
                               input logic last);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid               <= 1'b1;
        in_item.record_key     <= key;
        in_item.record_payload <= payload;
        in_item.batch_end      <= last;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // Stop sending and wait until every predicted sorted item has come out.
    task automatic drain_sorted();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_count == 0);
    endtask

    // order_mode is only written with the block idle
    task automatic set_order(input logic [MODE_W-1:0] mode);
        drain_sorted();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Keys biased toward ties, extremes and the sign boundary.
    function automatic logic [KEY_MAX_W-1:0] pick_key();
        logic [KEY_MAX_W-1:0] k;
        case ($urandom_range(0, 3))
            0: k = $urandom();
            1: k = $urandom_range(0, 7);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: k = 32'h0000_0000;
                    1: k = 32'hFFFF_FFFF;
                    2: k = 32'h8000_0000;
                    default: k = 32'h7FFF_FFFF;
                endcase
            end
            default: k = $urandom() & 32'hC000_0003;  // few distinct values, both signs
        endcase
        return k;
    endfunction

    // One batch of random records; with no_end the batch only closes on a full store.
    task automatic send_batch(input int size, input bit no_end);
        for (int i = 0; i < size; i++)
        begin
            send_record(pick_key(), $urandom(),
                        (i == size - 1) && !no_end);
        end
    endtask

    initial
    begin : stimulus
        int  rand_items;
        int  phase;
        int  batches;
        int  size;
        int  r;
        bit  no_end;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        tx_quiet  = 1'b0;
        rx_quiet  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, reset order first (ascending, unsigned).
        // A batch of one record comes out unchanged and flagged final.
        send_record(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        // ties on 5 and 0 keep load order
        send_record(32'h0000_0005, 32'h0000_00A1, 1'b0);
        send_record(32'h0000_0000, 32'h0000_00A2, 1'b0);
        send_record(32'h0000_0005, 32'h0000_00A3, 1'b0);
        send_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_record(32'h0000_0000, 32'h0000_00A5, 1'b1);

        set_order(ORDER_DESC_U);
        send_record(32'h0000_0000, 32'h0000_00B1, 1'b0);
        send_record(32'hFFFF_FFFF, 32'h0000_00B2, 1'b0);
        send_record(32'h0000_0000, 32'h0000_00B3, 1'b1);

        set_order(ORDER_ASC_S);
        send_record(32'h8000_0000, 32'h0000_00C1, 1'b0);
        send_record(32'h7FFF_FFFF, 32'h0000_00C2, 1'b0);
        send_record(32'hFFFF_FFFF, 32'h0000_00C3, 1'b0);
        send_record(32'h0000_0000, 32'h0000_00C4, 1'b1);

        set_order(ORDER_DESC_S);
        send_record(32'h7FFF_FFFF, 32'h0000_00D1, 1'b0);
        send_record(32'h8000_0000, 32'h0000_00D2, 1'b0);
        send_record(32'h7FFF_FFFF, 32'h0000_00D3, 1'b0);
        send_record(32'h0000_0001, 32'h0000_00D4, 1'b0);
        send_record(32'hFFFF_FFFF, 32'h0000_00D5, 1'b1);
        send_record(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);

        set_order(ORDER_ASC_U);

        // Random part: phases with a fresh order and idling style each.
        rand_items = 0;
        phase      = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            if (phase > 0)
            begin
                set_order(MODE_W'($urandom_range(0, 3)));
            end
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            batches  = $urandom_range(1, 4);
            for (int b = 0; b < batches; b++)
            begin
                if (phase == 0 && b == 0)
                begin
                    // store full with batch_end never set
                    size   = MAX_RECORDS_DEF;
                    no_end = 1'b1;
                end
                else
                begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                    begin
                        size   = MAX_RECORDS_DEF;
                        no_end = $urandom_range(0, 1);
                    end
                    else if (r == 1)
                    begin
                        size   = $urandom_range(13, MAX_RECORDS_DEF - 1);
                        no_end = 1'b0;
                    end
                    else
                    begin
                        size   = $urandom_range(1, 12);
                        no_end = 1'b0;
                    end
                end
                send_batch(size, no_end);
                rand_items += size;
                // once, hold the sender until everything sorted has drained
                if (phase == 2 && b == 0)
                begin
                    drain_sorted();
                end
            end
            phase++;
        end

        drain_sorted();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
src/smsort_pkg.sv
src/smsort_mem.sv
src/stable_merge_sorter_top.sv
src/smsort_checker.sv
test/smsort_order_checker.sv
test/stable_merge_sorter_top_tb.sv
